// ===== rtl/dfs_edge_classifier_defines.svh =====
// assertion macros for the edge classifier
`ifndef DFS_EDGE_CLASSIFIER_DEFINES_SVH
`define DFS_EDGE_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define DFS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DFS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/dfs_pkg.sv =====
package dfs_pkg;
   localparam int MaxNodesDef = 16;
   localparam int MaxEdgesDef = 64;

   localparam logic [1:0] CmdClear    = 2'd0;
   localparam logic [1:0] CmdAdd      = 2'd1;
   localparam logic [1:0] CmdClassify = 2'd2;
   localparam logic [1:0] CmdNone     = 2'd3;

   localparam logic [2:0] StReport  = 3'd0;
   localparam logic [2:0] StOk      = 3'd1;
   localparam logic [2:0] StBadId   = 3'd2;
   localparam logic [2:0] StFull    = 3'd3;
   localparam logic [2:0] StNoEdges = 3'd4;

   localparam logic [1:0] KindTree    = 2'd0;
   localparam logic [1:0] KindBack    = 2'd1;
   localparam logic [1:0] KindForward = 2'd2;
   localparam logic [1:0] KindCross   = 2'd3;

   localparam logic [1:0] ColWhite = 2'd0;
   localparam logic [1:0] ColGray  = 2'd1;
   localparam logic [1:0] ColBlack = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_ROOT, S_TOP, S_SCAN, S_EDGE, S_KIND, S_EMIT, S_POP, S_FINAL, S_OUT
   } state_type;
endpackage

// ===== rtl/dfs_edge_classifier.sv =====
// dfs edge classifier, one item at a time: clear gives its result in the cycle after
// the transfer, add via S_FINAL and S_OUT; ready again the cycle after the last result transfer
// classify: S_SCAN and S_EDGE per edge-table entry scanned per frame, S_ROOT, S_TOP, S_POP per node,
// S_KIND, S_EMIT, S_OUT per reported edge, plus result stalls; each report waits for the next
// so the final one carries tlast; the scan through one registered read port sets the rate
// reset (synchronous, active high) empties the edge table, sets node_count to 16
`include "dfs_edge_classifier_defines.svh"
module dfs_edge_classifier
   import dfs_pkg::*;
#(
   parameter int MAX_NODES = MaxNodesDef,
   parameter int MAX_EDGES = MaxEdgesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[1:0], source_node[6:2], dest_node[11:7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[2:0], edge_source[7:3], edge_dest[12:8], edge_kind[14:13]
   output logic        rsp_tlast
);
   localparam int NW = $clog2(MAX_NODES);
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int DW = $clog2(MAX_NODES + 1);
   localparam int TW = $clog2(MAX_NODES + 1);

   logic [4:0]    ncount_ff, ncount_in;
   logic [CW-1:0] total_ff, total_in;
   logic [NW-1:0] efrom_mem [MAX_EDGES];
   logic [NW-1:0] eto_mem   [MAX_EDGES];
   logic [NW-1:0] rd_from_ff, rd_to_ff;
   logic [1:0]    color_ff [MAX_NODES];
   logic [TW-1:0] dtime_mem [MAX_NODES];
   logic [NW-1:0] snode_mem [MAX_NODES];
   logic [CW-1:0] scur_mem  [MAX_NODES];
   logic [DW-1:0] depth_ff, depth_in;
   logic [TW-1:0] time_ff, time_in;
   logic [DW-1:0] root_ff, root_in;
   logic [NW-1:0] u_ff, u_in, v_ff, v_in;
   logic [CW-1:0] k_ff, k_in;
   logic [TW-1:0] du_ff, du_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]    st_ff, st_in;
   logic [4:0]    os_ff, os_in, od_ff, od_in;
   logic [1:0]    ok_ff, ok_in;
   logic          ol_ff, ol_in;
   logic          ocls_ff, ocls_in;
   logic [4:0]    ps_ff, ps_in, pd_ff, pd_in;
   logic [1:0]    pk_ff, pk_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [4:0]    src_ff, src_in, dst_ff, dst_in;
   state_type     state_ff, state_in;

   logic [4:0] neff;
   logic       we_edge, disc_we, cur_we, col_we, clr_col;
   logic [NW-1:0] col_idx;
   logic [1:0]    col_val;
   logic [NW-1:0] disc_node;
   logic [DW-1:0] stk_idx;
   logic [CW-1:0] cur_val;
   logic [DW-1:0] top;

   assign neff = (32'(ncount_ff) > MAX_NODES) ? 5'(MAX_NODES) : ncount_ff;
   assign top  = depth_ff - DW'(1);
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {1'b0, ok_ff, od_ff, os_ff, st_ff};
   assign rsp_tlast  = ol_ff;
   assign ncount_in  = (csr_valid && csr_ready) ? csr_data : ncount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ncount_ff <= 5'd16;
         total_ff  <= '0;
         depth_ff  <= '0;
         time_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ncount_ff <= ncount_in;
         total_ff  <= total_in;
         depth_ff  <= depth_in;
         time_ff   <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in; u_ff <= u_in; v_ff <= v_in; k_ff <= k_in; du_ff <= du_in;
      cnt_ff <= cnt_in; st_ff <= st_in; os_ff <= os_in; od_ff <= od_in; ok_ff <= ok_in;
      ol_ff <= ol_in; ocls_ff <= ocls_in; cmd_ff <= cmd_in; src_ff <= src_in;
      dst_ff <= dst_in; ps_ff <= ps_in; pd_ff <= pd_in; pk_ff <= pk_in;
   end

   always_ff @(posedge clock) begin
      if (we_edge) begin
         efrom_mem[total_ff[EW-1:0]] <= NW'(src_ff - 5'd1);
         eto_mem[total_ff[EW-1:0]]   <= NW'(dst_ff - 5'd1);
      end
      rd_from_ff <= efrom_mem[k_in[EW-1:0]];
      rd_to_ff   <= eto_mem[k_in[EW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (disc_we) begin
         dtime_mem[disc_node] <= time_ff;
         snode_mem[stk_idx[NW-1:0]] <= disc_node;
      end
      if (cur_we) scur_mem[stk_idx[NW-1:0]] <= cur_val;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NODES; i++) begin
         if (reset || clr_col) color_ff[i] <= ColWhite;
         else if (col_we && col_idx == NW'(i)) color_ff[i] <= col_val;
      end
   end

   always_comb begin
      state_in = state_ff; total_in = total_ff; depth_in = depth_ff; time_in = time_ff;
      root_in = root_ff; u_in = u_ff; v_in = v_ff; k_in = k_ff; du_in = du_ff;
      cnt_in = cnt_ff; st_in = st_ff; os_in = os_ff; od_in = od_ff; ok_in = ok_ff;
      ol_in = ol_ff; ocls_in = ocls_ff; cmd_in = cmd_ff; src_in = src_ff; dst_in = dst_ff;
      ps_in = ps_ff; pd_in = pd_ff; pk_in = pk_ff;
      we_edge = 1'b0; disc_we = 1'b0; cur_we = 1'b0; col_we = 1'b0; clr_col = 1'b0;
      col_idx = u_ff; col_val = ColGray; disc_node = v_ff; stk_idx = depth_ff;
      cur_val = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tdata[1:0];
               src_in = req_tdata[6:2];
               dst_in = req_tdata[11:7];
               os_in = '0; od_in = '0; ok_in = KindTree; ol_in = 1'b1; ocls_in = 1'b0;
               case (req_tdata[1:0])
                  CmdClear: begin
                     total_in = '0; st_in = StOk; state_in = S_OUT;
                  end
                  CmdAdd: state_in = S_FINAL;
                  CmdClassify: begin
                     clr_col = 1'b1; depth_in = '0; time_in = '0; root_in = '0;
                     cnt_in = '0; state_in = S_ROOT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FINAL: begin
            if (cmd_ff == CmdClassify) begin
               st_in = StNoEdges; os_in = '0; od_in = '0; ok_in = KindTree;
               ol_in = 1'b1; ocls_in = 1'b0;
            end else if (src_ff == 5'd0 || dst_ff == 5'd0 || src_ff > neff || dst_ff > neff)
               st_in = StBadId;
            else if (32'(total_ff) >= MAX_EDGES) st_in = StFull;
            else begin
               we_edge = 1'b1; total_in = total_ff + CW'(1); st_in = StOk;
            end
            state_in = S_OUT;
         end
         S_ROOT: begin
            if (32'(root_ff) >= 32'(neff)) begin
               if (cnt_ff == '0) state_in = S_FINAL;
               else begin
                  st_in = StReport; os_in = ps_ff; od_in = pd_ff; ok_in = pk_ff;
                  ol_in = 1'b1; ocls_in = 1'b0;
                  state_in = S_OUT;
               end
            end else begin
               root_in = root_ff + DW'(1);
               if (color_ff[root_ff[NW-1:0]] == ColWhite) begin
                  disc_we = 1'b1; disc_node = root_ff[NW-1:0]; cur_we = 1'b1;
                  col_we = 1'b1; col_idx = root_ff[NW-1:0]; col_val = ColGray;
                  time_in = time_ff + TW'(1); depth_in = depth_ff + DW'(1);
                  state_in = S_TOP;
               end
            end
         end
         S_TOP: begin
            if (depth_ff == '0) state_in = S_ROOT;
            else begin
               u_in = snode_mem[top[NW-1:0]];
               k_in = scur_mem[top[NW-1:0]];
               du_in = dtime_mem[snode_mem[top[NW-1:0]]];
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (k_ff >= total_ff) state_in = S_POP;
            else state_in = S_EDGE;
         end
         S_EDGE: begin
            if (rd_from_ff != u_ff) begin
               k_in = k_ff + CW'(1); state_in = S_SCAN;
            end else begin
               cur_we = 1'b1; stk_idx = top; cur_val = k_ff + CW'(1);
               v_in = rd_to_ff; state_in = S_KIND;
            end
         end
         S_KIND: begin
            ps_in = 5'(u_ff) + 5'd1; pd_in = 5'(v_ff) + 5'd1;
            if (color_ff[v_ff] == ColGray) pk_in = KindBack;
            else if (color_ff[v_ff] == ColBlack)
               pk_in = (du_ff < dtime_mem[v_ff]) ? KindForward : KindCross;
            else begin
               pk_in = KindTree;
               disc_we = 1'b1; cur_we = 1'b1; col_we = 1'b1; col_idx = v_ff;
               col_val = ColGray; time_in = time_ff + TW'(1); depth_in = depth_ff + DW'(1);
            end
            // the report before this one is known not to be the last
            st_in = StReport; os_in = ps_ff; od_in = pd_ff; ok_in = pk_ff;
            ol_in = 1'b0; ocls_in = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            state_in = (cnt_ff == '0) ? S_TOP : S_EMIT;
         end
         S_EMIT: begin
            state_in = S_OUT;
         end
         S_POP: begin
            col_we = 1'b1; col_idx = u_ff; col_val = ColBlack;
            depth_in = depth_ff - DW'(1);
            state_in = S_TOP;
         end
         S_OUT: begin
            if (rsp_tready) state_in = ocls_ff ? S_TOP : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `DFS_ASSERT_IMPL(a_busy_no_ready, clock, reset, state_ff != S_IDLE, !req_tready)
   `DFS_ASSERT_IMPL(a_depth_bound, clock, reset, 1'b1, 32'(depth_ff) <= MAX_NODES)
   `DFS_ASSERT_NEXT(a_clear_empties, clock, reset,
      req_tvalid && req_tready && req_tdata[1:0] == CmdClear, total_ff == '0)
endmodule

// ===== tb/sv/tb_dfs_edge_classifier.sv =====
`timescale 1ns / 100ps
module tb_dfs_edge_classifier;
   import dfs_pkg::*;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] src;
      logic [4:0] dst;
      logic [1:0] kind;
      logic       last;
   } edge_report_type;

   class edge_scoreboard;
      edge_report_type pending[$];
      int unsigned  errors;
      int unsigned  node_limit;
      logic [3:0]   tab_from[64];
      logic [3:0]   tab_to[64];
      int unsigned  tab_total;

      function new();
         node_limit = 16;
         tab_total  = 0;
         errors     = 0;
      endfunction

      function void push(logic [2:0] st, int unsigned s, int unsigned d, logic [1:0] k);
         edge_report_type r;
         r.status = st;
         r.src    = s[4:0];
         r.dst    = d[4:0];
         r.kind   = k;
         r.last   = 1'b0;
         pending.push_back(r);
      endfunction

      function void walk_graph();
         logic [1:0]  color[16];
         int unsigned disc[16];
         int unsigned stk_node[16];
         int unsigned stk_cur[16];
         int unsigned depth, clk_t, cnt, n, top, u, k, v;
         logic [1:0]  kd;
         depth = 0;
         clk_t = 0;
         cnt   = 0;
         n     = node_limit > 16 ? 16 : node_limit;
         for (int i = 0; i < 16; i++) begin
            color[i] = ColWhite;
            disc[i]  = 0;
         end
         for (int r = 0; r < n; r++) begin
            if (color[r] != ColWhite) continue;
            disc[r] = clk_t; clk_t++; color[r] = ColGray;
            stk_node[0] = r; stk_cur[0] = 0; depth = 1;
            while (depth > 0) begin
               top = depth - 1;
               u   = stk_node[top];
               k   = stk_cur[top];
               while (k < tab_total && 32'(tab_from[k]) != u) k++;
               if (k >= tab_total) begin
                  color[u] = ColBlack;
                  depth--;
                  continue;
               end
               stk_cur[top] = k + 1;
               v = 32'(tab_to[k]);
               if (color[v] == ColGray) kd = KindBack;
               else if (color[v] == ColBlack)
                  kd = (disc[u] < disc[v]) ? KindForward : KindCross;
               else kd = KindTree;
               if (cnt < 64) begin
                  push(StReport, u + 1, v + 1, kd);
                  cnt++;
               end
               if (kd == KindTree && depth < 16) begin
                  disc[v] = clk_t; clk_t++; color[v] = ColGray;
                  stk_node[depth] = v; stk_cur[depth] = 0; depth++;
               end
            end
         end
         if (cnt == 0) push(StNoEdges, 0, 0, KindTree);
      endfunction

      function void note_request(logic [1:0] cmd, logic [4:0] s, logic [4:0] d);
         int unsigned n;
         n = node_limit > 16 ? 16 : node_limit;
         if (cmd == CmdClear) begin
            tab_total = 0;
            push(StOk, 0, 0, KindTree);
         end else if (cmd == CmdAdd) begin
            if (s == 0 || d == 0 || s > n || d > n) push(StBadId, 0, 0, KindTree);
            else if (tab_total >= 64) push(StFull, 0, 0, KindTree);
            else begin
               tab_from[tab_total] = 4'(s - 5'd1);
               tab_to[tab_total]   = 4'(d - 5'd1);
               tab_total++;
               push(StOk, 0, 0, KindTree);
            end
         end else if (cmd == CmdClassify) begin
            walk_graph();
         end else begin
            return;
         end
         pending[$].last = 1'b1;
      endfunction

      function void check_result(logic [15:0] data, logic lst);
         edge_report_type want, got;
         got.status = data[2:0];
         got.src    = data[7:3];
         got.dst    = data[12:8];
         got.kind   = data[14:13];
         got.last   = lst;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want.status != got.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (want.src != got.src) begin
            $display("%0t: source expected %0d actual %0d", $time, want.src, got.src);
            errors++;
         end
         if (want.dst != got.dst) begin
            $display("%0t: dest expected %0d actual %0d", $time, want.dst, got.dst);
            errors++;
         end
         if (want.kind != got.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
         end
         if (want.last != got.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   edge_scoreboard sb = new();
   bit  hold_rsp = 1'b0;
   bit  no_stall = 1'b0;
   int  idle_cycles = 0;

   always #10 clock = ~clock;

   dfs_edge_classifier i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("dfs_edge_classifier verification failed");
         $finish;
      end
   end

   // result side
   initial begin
      int wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast);
            wait_left = no_stall ? 0 : $urandom_range(0, 19);
         end else if (wait_left > 0) begin
            wait_left--;
         end
         rsp_tready <= !hold_rsp && wait_left == 0;
      end
   end

   task automatic send(logic [1:0] cmd, logic [4:0] s, logic [4:0] d);
      int gap;
      gap = no_stall ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {4'b0, d, s, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, s, d);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [4:0] v);
      drain();
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.node_limit = v;
   endtask

   task automatic random_graph(int edges, int n);
      send(CmdClear, 5'($urandom), 5'($urandom));
      for (int i = 0; i < edges; i++) begin
         if ($urandom_range(0, 9) == 0)
            send(CmdAdd, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
         else
            send(CmdAdd, 5'($urandom_range(1, n)), 5'($urandom_range(1, n)));
      end
      send(CmdClassify, 5'($urandom), 5'($urandom));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send(CmdClassify, 5'd0, 5'd0);
      send(CmdAdd, 5'd0, 5'd1);
      send(CmdAdd, 5'd1, 5'd0);
      send(CmdAdd, 5'd17, 5'd1);
      send(CmdAdd, 5'd31, 5'd31);
      send(CmdAdd, 5'd1, 5'd2);
      send(CmdAdd, 5'd2, 5'd3);
      send(CmdAdd, 5'd3, 5'd1);
      send(CmdAdd, 5'd1, 5'd3);
      send(CmdAdd, 5'd4, 5'd2);
      send(CmdAdd, 5'd16, 5'd16);
      send(CmdAdd, 5'd16, 5'd5);
      send(CmdNone, 5'h1f, 5'h1f);
      send(CmdClassify, 5'h1f, 5'h1f);
      write_count(5'd2);
      send(CmdClassify, 5'd0, 5'd0);
      send(CmdAdd, 5'd3, 5'd1);
      write_count(5'd0);
      send(CmdAdd, 5'd1, 5'd1);
      send(CmdClassify, 5'd0, 5'd0);
      write_count(5'd31);
      send(CmdClear, 5'd0, 5'd0);
      for (int i = 0; i < 65; i++) send(CmdAdd, 5'((i % 16) + 1), 5'(((i * 7) % 16) + 1));
      send(CmdClassify, 5'd0, 5'd0);
      // receiver holds off while requests keep coming
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_graph(6, 5);
      join
      drain();
      // random
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: write_count(5'd16);
            1: write_count(5'd1);
            2: write_count(5'($urandom_range(2, 15)));
            default: write_count(5'($urandom_range(0, 31)));
         endcase
         no_stall = (ph % 5 == 4);
         random_graph($urandom_range(3, 18), sb.node_limit == 0 ? 1 :
                      (sb.node_limit > 16 ? 16 : sb.node_limit));
      end
      no_stall = 1'b0;
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("dfs_edge_classifier verification clean");
      else
         $display("dfs_edge_classifier verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dfs_pkg.sv
rtl/dfs_edge_classifier.sv
tb/sv/tb_dfs_edge_classifier.sv
